// ----- src/line_delimiter_guesser_defines.svh -----
// Assertion macros shared by the line delimiter guesser modules.
`ifndef LINE_DELIMITER_GUESSER_DEFINES_SVH
`define LINE_DELIMITER_GUESSER_DEFINES_SVH

// Checks that a condition holds at every clock edge outside reset.
`define LDG_ASSERT_ALWAYS(name, cond) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("%m: invariant violated");

// Checks that a trigger is followed by a consequence at the next clock edge.
`define LDG_ASSERT_NEXT(name, trig, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error("%m: expected follow-up missing");

`endif

// ----- src/ldg_pkg.sv -----
// Shared types, constants and functions of the line delimiter guesser.
package ldg_pkg;

  // Widths of the datapath.
  localparam int CLS_W  = 3;
  localparam int CNT_W  = 16;
  localparam int TOT_W  = 32;
  localparam int PAIR_W = TOT_W + 1;
  localparam int SUM_W  = TOT_W + 3;
  localparam int LHS_W  = TOT_W + 14;
  localparam int RHS_W  = SUM_W + 13;
  localparam int MAX_CLASSES = 8;

  // Defaults for the top-level parameters.
  localparam int DEF_CLASS_COUNT = 8;
  localparam int DEF_QUEUE_DEPTH = 4;

  // Share thresholds in units of one ten-thousandth.
  localparam int SCALE   = 10000;
  localparam int K_TAB   = 1667;
  localparam int K_SEMI  = 714;
  localparam int K_COLON = 4498;
  localparam int K_COMMA = 981;

  // Characters of interest.
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_PIPE  = 8'h7C;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NUL   = 8'h00;

  // Delimiter class indexes.
  localparam logic [CLS_W-1:0] CLS_COMMA = 3'd0;
  localparam logic [CLS_W-1:0] CLS_SEMI  = 3'd1;
  localparam logic [CLS_W-1:0] CLS_TAB   = 3'd2;
  localparam logic [CLS_W-1:0] CLS_PIPE  = 3'd3;
  localparam logic [CLS_W-1:0] CLS_COLON = 3'd4;
  localparam logic [CLS_W-1:0] CLS_DOT   = 3'd5;
  localparam logic [CLS_W-1:0] CLS_SPACE = 3'd6;
  localparam logic [CLS_W-1:0] CLS_NUL   = 3'd7;

  // Guess codes.
  localparam logic [1:0] GUESS_COMMA = 2'd0;
  localparam logic [1:0] GUESS_SEMI  = 2'd1;
  localparam logic [1:0] GUESS_TAB   = 2'd2;
  localparam logic [1:0] GUESS_COLON = 2'd3;

  // One classified byte as it waits in the queue.
  typedef struct packed {
    logic             counted;
    logic [CLS_W-1:0] cls;
    logic             last;
  } item_t;

  // One result, guess code in the lowest bits.
  typedef struct packed {
    logic [7:0]       eligible_mask;
    logic [CNT_W-1:0] guess_count;
    logic [7:0]       guess_char;
    logic [1:0]       guess_code;
  } result_t;

  // True when the byte belongs to one of the delimiter classes.
  function automatic logic class_hit(input logic [7:0] b);
    case (b)
      CH_COMMA, CH_SEMI, CH_TAB, CH_PIPE,
      CH_COLON, CH_DOT, CH_SPACE, CH_NUL: class_hit = 1'b1;
      default:                            class_hit = 1'b0;
    endcase
  endfunction

  // Class index of a delimiter byte.
  function automatic logic [CLS_W-1:0] class_idx(input logic [7:0] b);
    case (b)
      CH_COMMA: class_idx = CLS_COMMA;
      CH_SEMI:  class_idx = CLS_SEMI;
      CH_TAB:   class_idx = CLS_TAB;
      CH_PIPE:  class_idx = CLS_PIPE;
      CH_COLON: class_idx = CLS_COLON;
      CH_DOT:   class_idx = CLS_DOT;
      CH_SPACE: class_idx = CLS_SPACE;
      default:  class_idx = CLS_NUL;
    endcase
  endfunction

  // Character that belongs to a guess code.
  function automatic logic [7:0] guess_char_of(input logic [1:0] code);
    case (code)
      GUESS_COMMA: guess_char_of = CH_COMMA;
      GUESS_SEMI:  guess_char_of = CH_SEMI;
      GUESS_TAB:   guess_char_of = CH_TAB;
      default:     guess_char_of = CH_COLON;
    endcase
  endfunction

endpackage

// ----- src/ldg_front.sv -----
// Front end: byte intake, quote tracking and delimiter classification.
module ldg_front #(
  parameter int CLASS_COUNT = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_byte,
  input  logic          in_last,
  input  logic          q_full,
  output logic          q_push,
  output ldg_pkg::item_t q_item
);
  import ldg_pkg::*;

  logic in_quote;
  logic in_quote_next;
  logic [CLS_W-1:0] cls;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;
  assign cls      = class_idx(in_byte);

  // Quote state and classification of the current byte.
  always_comb begin
    in_quote_next  = in_quote;
    q_item.counted = 1'b0;
    q_item.cls     = cls;
    q_item.last    = in_last;
    if (in_quote) begin
      if (in_byte == CH_QUOTE) begin
        in_quote_next = 1'b0;
      end
    end else if (in_byte == CH_QUOTE) begin
      in_quote_next = 1'b1;
    end else begin
      q_item.counted = class_hit(in_byte) && (32'(cls) < CLASS_COUNT);
    end
    if (in_last) begin
      in_quote_next = 1'b0;
    end
  end

  // The quote state advances with every accepted transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_quote <= 1'b0;
    end else if (q_push) begin
      in_quote <= in_quote_next;
    end
  end

endmodule

// ----- src/ldg_fifo.sv -----
// Short queue of classified bytes between the front and back ends.
`include "line_delimiter_guesser_defines.svh"
module ldg_fifo #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ldg_pkg::item_t wr_item,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output ldg_pkg::item_t rd_item
);
  import ldg_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_QW = $clog2(DEPTH + 1);

  item_t             slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_QW-1:0] fill;

  assign full    = (fill == CNT_QW'(DEPTH));
  assign empty   = (fill == '0);
  assign rd_item = slots[rd_ptr];

  // Pointer wrap for any depth.
  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    bump = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  // Slot storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_item;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        fill <= fill + CNT_QW'(1);
      end else if (pop && !push) begin
        fill <= fill - CNT_QW'(1);
      end
    end
  end

  `LDG_ASSERT_ALWAYS(a_fill_in_range, fill <= CNT_QW'(DEPTH))

endmodule

// ----- src/ldg_back.sv -----
// Back end: per-line counting and the fold into consistent counts and totals.
`include "line_delimiter_guesser_defines.svh"
module ldg_back #(
  parameter int CLASS_COUNT = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_empty,
  input  ldg_pkg::item_t              q_item,
  output logic                        q_pop,
  input  logic                        advance,
  output logic                        fold_done,
  output logic [ldg_pkg::CNT_W-1:0]   cons [CLASS_COUNT],
  output logic [ldg_pkg::TOT_W-1:0]   tot  [CLASS_COUNT]
);
  import ldg_pkg::*;

  logic [CNT_W-1:0] line_cnt [CLASS_COUNT];
  logic [CNT_W-1:0] cnt_next [CLASS_COUNT];
  logic [PAIR_W-1:0] tot_sum [CLASS_COUNT];
  logic             counts_clear;

  assign q_pop = !q_empty && advance;

  // Line counts including the byte being retired, saturating at the top.
  always_comb begin
    counts_clear = 1'b1;
    for (int i = 0; i < CLASS_COUNT; i++) begin
      cnt_next[i] = line_cnt[i];
      if (q_item.counted && q_item.cls == CLS_W'(i) && line_cnt[i] != '1) begin
        cnt_next[i] = line_cnt[i] + CNT_W'(1);
      end
      tot_sum[i] = {1'b0, tot[i]} + PAIR_W'(cnt_next[i]);
      if (line_cnt[i] != '0) begin
        counts_clear = 1'b0;
      end
    end
  end

  // Counting, and at a line end the fold of each class with a nonzero count.
  always_ff @(posedge clk) begin
    if (rst) begin
      fold_done <= 1'b0;
      for (int i = 0; i < CLASS_COUNT; i++) begin
        line_cnt[i] <= '0;
        cons[i]     <= '1;
        tot[i]      <= '0;
      end
    end else if (advance) begin
      fold_done <= q_pop && q_item.last;
      if (q_pop) begin
        for (int i = 0; i < CLASS_COUNT; i++) begin
          if (q_item.last) begin
            line_cnt[i] <= '0;
            if (cnt_next[i] != '0) begin
              if (cons[i] > cnt_next[i]) begin
                cons[i] <= cnt_next[i];
              end else if (cons[i] != cnt_next[i]) begin
                cons[i] <= '0;
              end
              tot[i] <= tot_sum[i][PAIR_W-1] ? '1 : tot_sum[i][TOT_W-1:0];
            end
          end else begin
            line_cnt[i] <= cnt_next[i];
          end
        end
      end
    end
  end

  `LDG_ASSERT_NEXT(a_counts_cleared, advance && q_pop && q_item.last, counts_clear)

  // An inconsistent class stays inconsistent for good.
  for (genvar g = 0; g < CLASS_COUNT; g++) begin : g_sticky
    `LDG_ASSERT_NEXT(a_zero_sticks, cons[g] == '0, cons[g] == '0)
  end

endmodule

// ----- src/ldg_decide.sv -----
// Decision pipeline: eligible sums, exact share tests and the output register.
`include "line_delimiter_guesser_defines.svh"
module ldg_decide #(
  parameter int CLASS_COUNT = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      fold_done,
  input  logic [ldg_pkg::CNT_W-1:0] cons [CLASS_COUNT],
  input  logic [ldg_pkg::TOT_W-1:0] tot  [CLASS_COUNT],
  output logic                      advance,
  output logic                      m_valid,
  input  logic                      m_ready,
  output ldg_pkg::result_t          result
);
  import ldg_pkg::*;

  logic [CNT_W-1:0] cons8 [MAX_CLASSES];
  logic [TOT_W-1:0] tot8  [MAX_CLASSES];
  logic [TOT_W-1:0] tsel  [MAX_CLASSES];
  logic [7:0]       elig;

  // Stage 1 registers.
  logic              v1;
  logic [7:0]        s1_mask;
  logic [PAIR_W-1:0] s1_pair [4];
  logic [TOT_W-1:0]  s1_t_comma, s1_t_semi, s1_t_tab, s1_t_colon;
  logic [CNT_W-1:0]  s1_c_comma, s1_c_semi, s1_c_tab, s1_c_colon;

  // Stage 2 registers.
  logic              v2;
  logic [7:0]        s2_mask;
  logic [SUM_W-1:0]  s2_sum;
  logic [TOT_W-1:0]  s2_t_comma, s2_t_semi, s2_t_tab, s2_t_colon;
  logic [CNT_W-1:0]  s2_c_comma, s2_c_semi, s2_c_tab, s2_c_colon;

  // Stage 3 registers.
  logic              v3;
  logic [7:0]        s3_mask;
  logic [LHS_W-1:0]  s3_l_comma, s3_l_semi, s3_l_tab, s3_l_colon;
  logic [RHS_W-1:0]  s3_r_comma, s3_r_semi, s3_r_tab, s3_r_colon;
  logic              s3_tab_nz;
  logic [CNT_W-1:0]  s3_c_comma, s3_c_semi, s3_c_tab, s3_c_colon;

  logic le_tab, le_semi, le_colon, le_comma;
  logic [1:0]       code;
  logic [CNT_W-1:0] count_sel;

  // The whole pipeline moves whenever the output register can take a value.
  assign advance = !m_valid || m_ready;

  // Absent classes read as unset with an empty total.
  for (genvar g = 0; g < MAX_CLASSES; g++) begin : g_pad
    if (g < CLASS_COUNT) begin : g_have
      assign cons8[g] = cons[g];
      assign tot8[g]  = tot[g];
    end else begin : g_none
      assign cons8[g] = '1;
      assign tot8[g]  = '0;
    end
    assign elig[g] = (cons8[g] != '0) && !cons8[g][CNT_W-1];
    assign tsel[g] = elig[g] ? tot8[g] : '0;
  end

  // Stage 1: eligibility, masked totals and pairwise sums.
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_mask    <= elig;
      for (int j = 0; j < 4; j++) begin
        s1_pair[j] <= {1'b0, tsel[2*j]} + {1'b0, tsel[2*j+1]};
      end
      s1_t_comma <= tsel[CLS_COMMA];
      s1_t_semi  <= tsel[CLS_SEMI];
      s1_t_tab   <= tsel[CLS_TAB];
      s1_t_colon <= tsel[CLS_COLON];
      s1_c_comma <= cons8[CLS_COMMA];
      s1_c_semi  <= cons8[CLS_SEMI];
      s1_c_tab   <= cons8[CLS_TAB];
      s1_c_colon <= cons8[CLS_COLON];
    end
  end

  // Stage 2: sum of the eligible totals.
  always_ff @(posedge clk) begin
    if (advance) begin
      s2_mask    <= s1_mask;
      s2_sum     <= SUM_W'(s1_pair[0]) + SUM_W'(s1_pair[1])
                  + SUM_W'(s1_pair[2]) + SUM_W'(s1_pair[3]);
      s2_t_comma <= s1_t_comma;
      s2_t_semi  <= s1_t_semi;
      s2_t_tab   <= s1_t_tab;
      s2_t_colon <= s1_t_colon;
      s2_c_comma <= s1_c_comma;
      s2_c_semi  <= s1_c_semi;
      s2_c_tab   <= s1_c_tab;
      s2_c_colon <= s1_c_colon;
    end
  end

  // Stage 3: both sides of each share comparison, one multiplier apiece.
  always_ff @(posedge clk) begin
    if (advance) begin
      s3_mask    <= s2_mask;
      s3_l_comma <= LHS_W'(s2_t_comma) * LHS_W'(SCALE);
      s3_l_semi  <= LHS_W'(s2_t_semi) * LHS_W'(SCALE);
      s3_l_tab   <= LHS_W'(s2_t_tab) * LHS_W'(SCALE);
      s3_l_colon <= LHS_W'(s2_t_colon) * LHS_W'(SCALE);
      s3_r_comma <= RHS_W'(s2_sum) * RHS_W'(K_COMMA);
      s3_r_semi  <= RHS_W'(s2_sum) * RHS_W'(K_SEMI);
      s3_r_tab   <= RHS_W'(s2_sum) * RHS_W'(K_TAB);
      s3_r_colon <= RHS_W'(s2_sum) * RHS_W'(K_COLON);
      s3_tab_nz  <= (s2_t_tab != '0);
      s3_c_comma <= s2_c_comma;
      s3_c_semi  <= s2_c_semi;
      s3_c_tab   <= s2_c_tab;
      s3_c_colon <= s2_c_colon;
    end
  end

  // Valid bits of the pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1      <= 1'b0;
      v2      <= 1'b0;
      v3      <= 1'b0;
      m_valid <= 1'b0;
    end else if (advance) begin
      v1      <= fold_done;
      v2      <= v1;
      v3      <= v2;
      m_valid <= v3;
    end
  end

  // Decision list over the share comparisons.
  always_comb begin
    le_tab   = RHS_W'(s3_l_tab) <= s3_r_tab;
    le_semi  = RHS_W'(s3_l_semi) <= s3_r_semi;
    le_colon = RHS_W'(s3_l_colon) <= s3_r_colon;
    le_comma = RHS_W'(s3_l_comma) <= s3_r_comma;
    if (le_tab && le_semi && le_colon) begin
      code = GUESS_COMMA;
    end else if (le_semi && s3_tab_nz) begin
      code = GUESS_TAB;
    end else if (!le_semi) begin
      code = GUESS_SEMI;
    end else if (le_comma) begin
      code = GUESS_COLON;
    end else begin
      code = GUESS_COMMA;
    end
    case (code)
      GUESS_COMMA: count_sel = s3_c_comma;
      GUESS_SEMI:  count_sel = s3_c_semi;
      GUESS_TAB:   count_sel = s3_c_tab;
      default:     count_sel = s3_c_colon;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (advance) begin
      result.guess_code    <= code;
      result.guess_char    <= guess_char_of(code);
      result.guess_count   <= count_sel;
      result.eligible_mask <= s3_mask;
    end
  end

  `LDG_ASSERT_NEXT(a_result_reaches_output, v3 && advance, m_valid)

endmodule

// ----- src/line_delimiter_guesser.sv -----
// Top level of the line delimiter guesser.
//
//  channel  | dir | tdata / tuser                         | tlast
//  s_axis   | in  | tdata[7:0] text_byte                  | line_end
//  m_axis   | out | tdata[39:0] guess_code, guess_char,   | none
//           |     | guess_count, eligible_mask            |
//
// One byte is taken per cycle while the queue is not full; the queue and the
// back end retire one byte per cycle while the output is not stalled, so a
// steady stream runs at one transaction a cycle. A line-end byte from the queue
// passes the fold register, the sum and product stages and the output register.
// Reset is synchronous and clears quote state, counts, totals and valid bits.
// A stalled output holds the whole back end; the front keeps taking bytes until
// the queue of QUEUE_DEPTH entries is full.
module line_delimiter_guesser #(
  parameter int CLASS_COUNT = ldg_pkg::DEF_CLASS_COUNT,
  parameter int QUEUE_DEPTH = ldg_pkg::DEF_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // [1:0] guess_code, [9:2] guess_char,
                                      // [25:10] guess_count, [33:26] eligible_mask
);
  import ldg_pkg::*;

  logic             q_full;
  logic             q_push;
  item_t            q_wr_item;
  logic             q_empty;
  logic             q_pop;
  item_t            q_rd_item;
  logic             advance;
  logic             fold_done;
  logic [CNT_W-1:0] cons [CLASS_COUNT];
  logic [TOT_W-1:0] tot  [CLASS_COUNT];
  result_t          result;

  // Intake and classification.
  ldg_front #(.CLASS_COUNT(CLASS_COUNT)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_byte  (s_axis_tdata),
    .in_last  (s_axis_tlast),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_wr_item)
  );

  // Decoupling queue.
  ldg_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_item (q_wr_item),
    .full    (q_full),
    .pop     (q_pop),
    .empty   (q_empty),
    .rd_item (q_rd_item)
  );

  // Counting and fold.
  ldg_back #(.CLASS_COUNT(CLASS_COUNT)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_item    (q_rd_item),
    .q_pop     (q_pop),
    .advance   (advance),
    .fold_done (fold_done),
    .cons      (cons),
    .tot       (tot)
  );

  // Decision and output.
  ldg_decide #(.CLASS_COUNT(CLASS_COUNT)) u_decide (
    .clk       (clk),
    .rst       (rst),
    .fold_done (fold_done),
    .cons      (cons),
    .tot       (tot),
    .advance   (advance),
    .m_valid   (m_axis_tvalid),
    .m_ready   (m_axis_tready),
    .result    (result)
  );

  assign m_axis_tdata = {6'b0, result};

endmodule

// ----- test/tb_top.sv -----
// Self-checking stream testbench for the line delimiter guesser.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ldg_pkg::*;

  localparam int N_CLASSES = DEF_CLASS_COUNT;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int DRAIN_CYCLES = 24;
  localparam int ELIGIBLE_MAX = 32767;
  localparam logic [15:0] UNSET = 16'hFFFF;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] text_byte
  logic        s_axis_tlast = 1'b0;    // line_end
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;           // [1:0] guess_code, [9:2] guess_char,
                                       // [25:10] guess_count, [33:26] eligible_mask

  line_delimiter_guesser uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #10 clk = ~clk;

  // Shadow state of the guesser.
  logic        in_quote_m;
  logic [15:0] line_tally [8];
  logic [15:0] steady_count [8];
  logic [31:0] class_total [8];
  result_t     guess_q [$];

  // Stimulus and flow control.
  logic [7:0] line_buf [$];
  int presence_pct [8];
  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;

  // Delimiter class of a byte, or -1 for any other byte.
  function automatic int class_of_byte(logic [7:0] b);
    case (b)
      CH_COMMA: return int'(CLS_COMMA);
      CH_SEMI:  return int'(CLS_SEMI);
      CH_TAB:   return int'(CLS_TAB);
      CH_PIPE:  return int'(CLS_PIPE);
      CH_COLON: return int'(CLS_COLON);
      CH_DOT:   return int'(CLS_DOT);
      CH_SPACE: return int'(CLS_SPACE);
      CH_NUL:   return int'(CLS_NUL);
      default:  return -1;
    endcase
  endfunction

  // Byte that stands for a delimiter class.
  function automatic logic [7:0] class_char(int c);
    case (c)
      int'(CLS_COMMA): return CH_COMMA;
      int'(CLS_SEMI):  return CH_SEMI;
      int'(CLS_TAB):   return CH_TAB;
      int'(CLS_PIPE):  return CH_PIPE;
      int'(CLS_COLON): return CH_COLON;
      int'(CLS_DOT):   return CH_DOT;
      int'(CLS_SPACE): return CH_SPACE;
      default:         return CH_NUL;
    endcase
  endfunction

  function automatic bit is_eligible(int c);
    return c < N_CLASSES && steady_count[c] >= 1 && steady_count[c] <= ELIGIBLE_MAX;
  endfunction

  // Exact test of share(c) <= k / SCALE by cross-multiplication.
  function automatic bit share_within(int c, longint unsigned k, longint unsigned sum);
    longint unsigned num;
    num = is_eligible(c) ? longint'(class_total[c]) : 0;
    return num * SCALE <= k * sum;
  endfunction

  function automatic void reset_shadow();
    in_quote_m = 1'b0;
    for (int i = 0; i < 8; i++) begin
      line_tally[i] = '0;
      steady_count[i] = UNSET;
      class_total[i] = '0;
    end
  endfunction

  // Advances the shadow state by one byte and queues the guess at a line end.
  function automatic void predict_guess(logic [7:0] b, logic last);
    int c;
    int cls;
    longint unsigned sum;
    logic [32:0] grown;
    logic [7:0] mask;
    result_t r;
    if (in_quote_m) begin
      if (b == CH_QUOTE) in_quote_m = 1'b0;
    end else if (b == CH_QUOTE) begin
      in_quote_m = 1'b1;
    end else begin
      c = class_of_byte(b);
      if (c >= 0 && c < N_CLASSES && line_tally[c] != UNSET) line_tally[c]++;
    end
    if (!last) return;

    // Fold the line into the consistent counts and the saturating totals.
    for (int i = 0; i < N_CLASSES; i++) begin
      if (line_tally[i] != 0) begin
        if (steady_count[i] > line_tally[i]) steady_count[i] = line_tally[i];
        else if (steady_count[i] != line_tally[i]) steady_count[i] = '0;
        grown = class_total[i] + line_tally[i];
        class_total[i] = grown[32] ? 32'hFFFF_FFFF : grown[31:0];
      end
      line_tally[i] = '0;
    end
    in_quote_m = 1'b0;

    sum = 0;
    mask = '0;
    for (int i = 0; i < 8; i++) begin
      if (is_eligible(i)) begin
        sum += class_total[i];
        mask[i] = 1'b1;
      end
    end

    // Fixed decision list over the shares.
    if (share_within(CLS_TAB, K_TAB, sum) && share_within(CLS_SEMI, K_SEMI, sum) &&
        share_within(CLS_COLON, K_COLON, sum))
      r.guess_code = GUESS_COMMA;
    else if (share_within(CLS_SEMI, K_SEMI, sum) && is_eligible(CLS_TAB) &&
             class_total[CLS_TAB] != 0)
      r.guess_code = GUESS_TAB;
    else if (!share_within(CLS_SEMI, K_SEMI, sum))
      r.guess_code = GUESS_SEMI;
    else if (share_within(CLS_COMMA, K_COMMA, sum))
      r.guess_code = GUESS_COLON;
    else
      r.guess_code = GUESS_COMMA;

    case (r.guess_code)
      GUESS_COMMA: cls = CLS_COMMA;
      GUESS_SEMI:  cls = CLS_SEMI;
      GUESS_TAB:   cls = CLS_TAB;
      default:     cls = CLS_COLON;
    endcase
    r.guess_char = class_char(cls);
    r.guess_count = (cls < N_CLASSES) ? steady_count[cls] : UNSET;
    r.eligible_mask = mask;
    guess_q.push_back(r);
  endfunction

  function automatic void report_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    end
  endfunction

  // Compares one output transaction with the oldest queued guess.
  function automatic void check_guess(logic [39:0] d);
    result_t want;
    result_t got;
    got = d[$bits(result_t)-1:0];
    if (guess_q.size() == 0) begin
      errors++;
      $display("%0t: result expected none actual %h", $time, d);
      return;
    end
    want = guess_q.pop_front();
    report_field("guess_code", want.guess_code, got.guess_code);
    report_field("guess_char", want.guess_char, got.guess_char);
    report_field("guess_count", want.guess_count, got.guess_count);
    report_field("eligible_mask", want.eligible_mask, got.eligible_mask);
    report_field("padding", 0, d[39:$bits(result_t)]);
  endfunction

  // Result side: check accepted transactions and drive the ready with stalls.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) check_guess(m_axis_tdata);
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Offers one byte, with random gaps, and waits for its transaction.
  task automatic send_byte(logic [7:0] b, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    predict_guess(b, last);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tlast <= last;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic send_line();
    for (int i = 0; i < line_buf.size(); i++) send_byte(line_buf[i], i == line_buf.size() - 1);
    line_buf.delete();
  endtask

  task automatic send_text(string s);
    line_buf.delete();
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
    send_line();
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (guess_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] filler_byte();
    logic [7:0] b;
    do b = $urandom_range(255); while (b == CH_QUOTE || class_of_byte(b) >= 0);
    return b;
  endfunction

  // Content of a quoted span: delimiters half the time, never a quote.
  function automatic logic [7:0] quoted_byte();
    logic [7:0] b;
    if ($urandom_range(1)) return class_char($urandom_range(7));
    do b = $urandom_range(255); while (b == CH_QUOTE);
    return b;
  endfunction

  // Count for a class that keeps the consistent count alive most of the time.
  function automatic int pick_count(int c);
    logic [15:0] s;
    s = steady_count[c];
    if ($urandom_range(99) >= presence_pct[c]) return 0;
    if (s == UNSET) return $urandom_range(6, 1);
    if (s == 0 || s > ELIGIBLE_MAX) return $urandom_range(2);
    if ($urandom_range(99) < 75) return s;
    return $urandom_range(s, 1);
  endfunction

  task automatic push_quote_span();
    line_buf.push_back(CH_QUOTE);
    repeat ($urandom_range(4)) line_buf.push_back(quoted_byte());
  endtask

  // Builds a line in line_buf: mostly well-formed, sometimes noise or broken.
  task automatic build_line();
    logic [7:0] plain [$];
    logic [7:0] tmp;
    int n;
    int j;
    int broken;
    line_buf.delete();
    if ($urandom_range(99) < 6) begin
      repeat ($urandom_range(16, 1)) line_buf.push_back($urandom_range(255));
    end else begin
      broken = ($urandom_range(99) < 2) ? $urandom_range(5) : -1;
      for (int c = 0; c < 8; c++) begin
        n = pick_count(c);
        if (c == broken)
          n = (steady_count[c] >= 1 && steady_count[c] <= ELIGIBLE_MAX) ?
              steady_count[c] + 1 : 3;
        repeat (n) plain.push_back(class_char(c));
      end
      repeat ($urandom_range(4)) plain.push_back(filler_byte());
      if (plain.size() == 0) plain.push_back(filler_byte());
      for (int i = plain.size() - 1; i > 0; i--) begin
        j = $urandom_range(i);
        tmp = plain[i];
        plain[i] = plain[j];
        plain[j] = tmp;
      end
      foreach (plain[i]) begin
        if ($urandom_range(99) < 12) begin
          push_quote_span();
          line_buf.push_back(CH_QUOTE);
        end
        line_buf.push_back(plain[i]);
      end
      // A quote left open at the line end.
      if ($urandom_range(99) < 8) push_quote_span();
    end
  endtask

  task automatic test_no_delimiter();
    send_idle_pct = 0;
    stall_pct = 0;
    line_buf.delete();
    line_buf.push_back(8'h7F);
    line_buf.push_back(8'hFF);
    send_line();
  endtask

  // One line per outcome of the decision list: colon, comma, tab, semicolon.
  task automatic test_each_guess();
    send_text("a::::b");
    send_text(",,,,::::");
    send_text("\t\t\t\t");
    send_text(";;;;x");
  endtask

  task automatic test_quoting();
    send_text("\";:\",,,,");
    send_text("::::\",,");
    send_text(",,,,");
    send_text("::::\"");
    send_text(";;;;");
    send_text("\"\"::::");
  endtask

  task automatic test_other_classes();
    send_text("|.a");
  endtask

  task automatic run_random_phase(int idle, int stall, int n_items);
    int sent;
    send_idle_pct = idle;
    stall_pct = stall;
    sent = 0;
    while (sent < n_items) begin
      if (sent % 300 < 15)
        for (int c = 0; c < 8; c++) presence_pct[c] = $urandom_range(100);
      build_line();
      sent += line_buf.size();
      send_line();
    end
  endtask

  task automatic test_random();
    run_random_phase(0, 0, 390);
    run_random_phase(72, 0, 390);
    wait_drained();
    run_random_phase(0, 72, 390);
    run_random_phase(10, 10, 390);
  endtask

  // Long receiver hold-off while the sender keeps offering, then a full drain.
  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct = 0;
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    hold_left = 400;
    @(posedge clk);
    repeat (40) begin
      build_line();
      send_line();
    end
    wait_drained();
  endtask

  initial begin
    reset_shadow();
    for (int c = 0; c < 8; c++) presence_pct[c] = 50;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_no_delimiter();
    test_each_guess();
    test_quoting();
    test_other_classes();
    test_random();
    test_backpressure();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
